// ===== src/fpsac_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame parser package
// Types and constants shared by the frame parser modules: phase codes,
// status codes, register indexes and the result record.
// ----------------------------------------------------------------------------
package fpsac_pkg;

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_ADDR    = 3'd1;
    localparam logic [2:0] PH_ID      = 3'd2;
    localparam logic [2:0] PH_LEN     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_SUM     = 3'd5;
    localparam logic [2:0] PH_ADD     = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SUM_FAIL = 2'd1;
    localparam logic [1:0] ST_ADD_FAIL = 2'd2;

    localparam logic       KIND_PAYLOAD = 1'b0;
    localparam logic       KIND_END     = 1'b1;

    localparam logic       CFG_HEADER_BYTE  = 1'b0;
    localparam logic       CFG_HOST_ADDRESS = 1'b1;

    localparam logic [7:0] HEADER_RESET  = 8'hAA;
    localparam logic [7:0] ADDRESS_RESET = 8'h00;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [7:0] frame_address;
        logic [7:0] frame_id;
        logic [7:0] frame_length;
        logic [1:0] status;
        logic       for_host;
        logic       last;
    } t_result;

endpackage

// ===== src/frame_parser_sum_add_check_unit.sv =====
// ----------------------------------------------------------------------------
// Frame parser with sum and add checks
// Received bytes enter on the rx channel (valid/ready), one per transaction.
// The parser hunts for the header byte, then takes address, id and length
// bytes, the payload and two check bytes. Each payload byte gives one result
// transaction carrying its index; the add check byte gives an end-of-frame
// report with its status and the addressed-to-host flag. Other bytes give no
// result. Results leave on the out channel (valid/ready), one field a port.
// A byte is taken every cycle while rx ready is high; the parser state
// updates in the cycle a byte is taken, and its result is registered in
// the output register, or in the skid register behind it. When the receiver
// stalls, bytes are still taken until a second result is waiting in the
// skid register; rx ready then drops until the receiver takes the stalled
// result. The configuration port writes header_byte (index 0) and
// host_address (index 1); the user must write them only while the block
// is idle, not enforced by the block. Synchronous reset returns the parser
// to hunting, empties the result stage and restores header 0xAA, host 0x00.
// ----------------------------------------------------------------------------
module frame_parser_sum_add_check_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_kind,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_byte_index,
    output logic [7:0] o_frame_address,
    output logic [7:0] o_frame_id,
    output logic [7:0] o_frame_length,
    output logic [1:0] o_status,
    output logic       o_for_host,
    output logic       o_last
);

    logic [7:0]         r_header_byte;
    logic [7:0]         r_host_address;
    logic               rx_accept;
    logic               res_valid;
    fpsac_pkg::t_result res;
    fpsac_pkg::t_result out;

    assign rx_accept = i_rx_valid && o_rx_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_byte  <= fpsac_pkg::HEADER_RESET;
            r_host_address <= fpsac_pkg::ADDRESS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fpsac_pkg::CFG_HEADER_BYTE:  r_header_byte  <= i_cfg_data;
                fpsac_pkg::CFG_HOST_ADDRESS: r_host_address <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    fpsac_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (rx_accept),
        .i_rx_byte      (i_rx_byte),
        .i_header_byte  (r_header_byte),
        .i_host_address (r_host_address),
        .o_res_valid    (res_valid),
        .o_result       (res)
    );

    fpsac_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (rx_accept && res_valid),
        .i_result (res),
        .o_ready  (o_rx_ready),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out)
    );

    assign o_kind          = out.kind;
    assign o_data_byte     = out.data_byte;
    assign o_byte_index    = out.byte_index;
    assign o_frame_address = out.frame_address;
    assign o_frame_id      = out.frame_id;
    assign o_frame_length  = out.frame_length;
    assign o_status        = out.status;
    assign o_for_host      = out.for_host;
    assign o_last          = out.last;

    a_last_is_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == o_kind))
        else $error("last flag differs from result kind");

    a_end_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_data_byte == 8'd0 && o_byte_index == 8'd0))
        else $error("end report carries payload data");

    a_status_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (o_status == fpsac_pkg::ST_OK))
        else $error("payload result carries a status");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rx_ready |-> o_out_valid)
        else $error("rx stalled with an empty output register");

endmodule

// ===== src/fpsac_parser.sv =====
// ----------------------------------------------------------------------------
// Frame parser state machine
// Holds the frame phase, header fields and both running checksums, and
// forms the result caused by each accepted byte in the same cycle.
// ----------------------------------------------------------------------------
module fpsac_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    input  logic [7:0]          i_header_byte,
    input  logic [7:0]          i_host_address,
    output logic                o_res_valid,
    output fpsac_pkg::t_result  o_result
);

    logic [2:0] r_phase,   n_phase;
    logic [7:0] r_address, n_address;
    logic [7:0] r_id,      n_id;
    logic [7:0] r_length,  n_length;
    logic [7:0] r_count,   n_count;
    logic [7:0] r_sum,     n_sum;
    logic [7:0] r_add,     n_add;
    logic       r_sum_ok,  n_sum_ok;

    logic [7:0] sum_next;
    logic [7:0] add_next;
    logic [7:0] count_inc;

    assign sum_next  = r_sum + i_rx_byte;
    assign add_next  = r_add + sum_next;
    assign count_inc = r_count + 8'd1;

    always_comb begin
        n_phase     = r_phase;
        n_address   = r_address;
        n_id        = r_id;
        n_length    = r_length;
        n_count     = r_count;
        n_sum       = r_sum;
        n_add       = r_add;
        n_sum_ok    = r_sum_ok;
        o_res_valid = 1'b0;

        o_result.kind          = fpsac_pkg::KIND_PAYLOAD;
        o_result.data_byte     = i_rx_byte;
        o_result.byte_index    = r_count;
        o_result.frame_address = r_address;
        o_result.frame_id      = r_id;
        o_result.frame_length  = r_length;
        o_result.status        = fpsac_pkg::ST_OK;
        o_result.for_host      = (r_address == i_host_address);
        o_result.last          = 1'b0;

        case (r_phase)
            fpsac_pkg::PH_ADDR: begin
                n_address = i_rx_byte;
                n_sum     = sum_next;
                n_add     = add_next;
                n_phase   = fpsac_pkg::PH_ID;
            end
            fpsac_pkg::PH_ID: begin
                n_id    = i_rx_byte;
                n_sum   = sum_next;
                n_add   = add_next;
                n_phase = fpsac_pkg::PH_LEN;
            end
            fpsac_pkg::PH_LEN: begin
                n_length = i_rx_byte;
                n_sum    = sum_next;
                n_add    = add_next;
                n_count  = 8'd0;
                n_phase  = (i_rx_byte == 8'd0) ? fpsac_pkg::PH_SUM : fpsac_pkg::PH_PAYLOAD;
            end
            fpsac_pkg::PH_PAYLOAD: begin
                n_sum       = sum_next;
                n_add       = add_next;
                n_count     = count_inc;
                o_res_valid = 1'b1;
                if (count_inc == r_length) begin
                    n_phase = fpsac_pkg::PH_SUM;
                end
            end
            fpsac_pkg::PH_SUM: begin
                n_sum_ok = (i_rx_byte == r_sum);
                n_phase  = fpsac_pkg::PH_ADD;
            end
            fpsac_pkg::PH_ADD: begin
                o_res_valid         = 1'b1;
                o_result.kind       = fpsac_pkg::KIND_END;
                o_result.data_byte  = 8'd0;
                o_result.byte_index = 8'd0;
                o_result.last       = 1'b1;
                if (!r_sum_ok) begin
                    o_result.status = fpsac_pkg::ST_SUM_FAIL;
                end else if (i_rx_byte != r_add) begin
                    o_result.status = fpsac_pkg::ST_ADD_FAIL;
                end
                n_phase = fpsac_pkg::PH_HUNT;
            end
            default: begin
                n_phase = fpsac_pkg::PH_HUNT;
                if (i_rx_byte == i_header_byte) begin
                    n_sum    = i_rx_byte;
                    n_add    = i_rx_byte;
                    n_sum_ok = 1'b0;
                    n_phase  = fpsac_pkg::PH_ADDR;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= fpsac_pkg::PH_HUNT;
            r_address <= 8'd0;
            r_id      <= 8'd0;
            r_length  <= 8'd0;
            r_count   <= 8'd0;
            r_sum     <= 8'd0;
            r_add     <= 8'd0;
            r_sum_ok  <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_address <= n_address;
            r_id      <= n_id;
            r_length  <= n_length;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_add     <= n_add;
            r_sum_ok  <= n_sum_ok;
        end
    end

endmodule

// ===== src/fpsac_out_stage.sv =====
// ----------------------------------------------------------------------------
// Frame parser result stage
// Output register backed by a skid register, so that a byte can be taken
// in the cycle in which the receiver stalls a finished result.
// ----------------------------------------------------------------------------
module fpsac_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  fpsac_pkg::t_result  i_result,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output fpsac_pkg::t_result  o_result
);

    logic               r_out_valid;
    fpsac_pkg::t_result r_out;
    logic               r_skid_valid;
    fpsac_pkg::t_result r_skid;

    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
            end
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end else if (i_valid) begin
            r_skid <= i_result;
        end
    end

endmodule

// ===== dv/frame_parser_sum_add_check_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Frame parser testbench
// Drives received bytes into the frame parser through its valid/ready input
// channel and checks every result transaction against a cycle-free model of
// the parser held in a small scoreboard class. Stimulus starts with a few
// directed frames (extreme field values, zero length, both failing checks,
// header value inside a frame) and then runs several register settings with
// random frames, noise and truncated frames, under random idling on both
// channels, one long receiver hold-off and full drains between settings.
// ----------------------------------------------------------------------------
module frame_parser_sum_add_check_unit_tb;

    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 40;
    localparam int SETTLE      = 4;

    class frame_scoreboard;
        logic [7:0]         header_byte;
        logic [7:0]         host_address;
        logic [2:0]         phase;
        logic [7:0]         held_address;
        logic [7:0]         held_id;
        logic [7:0]         held_length;
        logic [7:0]         payload_count;
        logic [7:0]         running_sum;
        logic [7:0]         running_add;
        logic               sum_matched;
        fpsac_pkg::t_result expected_q[$];
        int                 errors;

        function void reset_state();
            header_byte   = fpsac_pkg::HEADER_RESET;
            host_address  = fpsac_pkg::ADDRESS_RESET;
            phase         = fpsac_pkg::PH_HUNT;
            held_address  = '0;
            held_id       = '0;
            held_length   = '0;
            payload_count = '0;
            running_sum   = '0;
            running_add   = '0;
            sum_matched   = 1'b0;
            expected_q.delete();
        endfunction

        function void write_reg(logic idx, logic [7:0] value);
            if (idx == fpsac_pkg::CFG_HEADER_BYTE) begin
                header_byte = value;
            end else begin
                host_address = value;
            end
        endfunction

        function void add_to_sums(logic [7:0] b);
            running_sum = running_sum + b;
            running_add = running_add + running_sum;
        endfunction

        function fpsac_pkg::t_result frame_result(logic kind, logic [7:0] data,
                                                  logic [7:0] idx, logic [1:0] status);
            fpsac_pkg::t_result r;
            r.kind          = kind;
            r.data_byte     = data;
            r.byte_index    = idx;
            r.frame_address = held_address;
            r.frame_id      = held_id;
            r.frame_length  = held_length;
            r.status        = status;
            r.for_host      = (held_address == host_address);
            r.last          = kind;
            return r;
        endfunction

        function void note_byte(logic [7:0] b);
            logic [1:0] status;
            case (phase)
                fpsac_pkg::PH_ADDR: begin
                    held_address = b;
                    add_to_sums(b);
                    phase = fpsac_pkg::PH_ID;
                end
                fpsac_pkg::PH_ID: begin
                    held_id = b;
                    add_to_sums(b);
                    phase = fpsac_pkg::PH_LEN;
                end
                fpsac_pkg::PH_LEN: begin
                    held_length = b;
                    add_to_sums(b);
                    payload_count = '0;
                    phase = (b == 8'd0) ? fpsac_pkg::PH_SUM : fpsac_pkg::PH_PAYLOAD;
                end
                fpsac_pkg::PH_PAYLOAD: begin
                    add_to_sums(b);
                    expected_q.push_back(frame_result(fpsac_pkg::KIND_PAYLOAD, b,
                                                      payload_count, fpsac_pkg::ST_OK));
                    payload_count = payload_count + 8'd1;
                    if (payload_count == held_length) begin
                        phase = fpsac_pkg::PH_SUM;
                    end
                end
                fpsac_pkg::PH_SUM: begin
                    sum_matched = (b == running_sum);
                    phase = fpsac_pkg::PH_ADD;
                end
                fpsac_pkg::PH_ADD: begin
                    if (!sum_matched) begin
                        status = fpsac_pkg::ST_SUM_FAIL;
                    end else if (b != running_add) begin
                        status = fpsac_pkg::ST_ADD_FAIL;
                    end else begin
                        status = fpsac_pkg::ST_OK;
                    end
                    expected_q.push_back(frame_result(fpsac_pkg::KIND_END, 8'd0, 8'd0,
                                                      status));
                    phase = fpsac_pkg::PH_HUNT;
                end
                default: begin
                    phase = fpsac_pkg::PH_HUNT;
                    if (b == header_byte) begin
                        running_sum = '0;
                        running_add = '0;
                        add_to_sums(b);
                        sum_matched = 1'b0;
                        phase = fpsac_pkg::PH_ADDR;
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(fpsac_pkg::t_result got);
            fpsac_pkg::t_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transaction, expected none, actual %h",
                         $time, got);
            end else begin
                want = expected_q.pop_front();
                compare_field("kind", 8'(want.kind), 8'(got.kind));
                compare_field("data_byte", want.data_byte, got.data_byte);
                compare_field("byte_index", want.byte_index, got.byte_index);
                compare_field("frame_address", want.frame_address, got.frame_address);
                compare_field("frame_id", want.frame_id, got.frame_id);
                compare_field("frame_length", want.frame_length, got.frame_length);
                compare_field("status", 8'(want.status), 8'(got.status));
                compare_field("for_host", 8'(want.for_host), 8'(got.for_host));
                compare_field("last", 8'(want.last), 8'(got.last));
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;
    logic       out_ready;

    logic       rx_ready;
    logic       out_valid;
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_address;
    logic [7:0] frame_id;
    logic [7:0] frame_length;
    logic [1:0] status;
    logic       for_host;
    logic       last;

    frame_scoreboard sb;
    logic [7:0]      cur_header;
    logic [7:0]      cur_host;
    bit              quiet;
    bit              hold_req;

    frame_parser_sum_add_check_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_rx_valid      (rx_valid),
        .o_rx_ready      (rx_ready),
        .i_rx_byte       (rx_byte),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_kind          (kind),
        .o_data_byte     (data_byte),
        .o_byte_index    (byte_index),
        .o_frame_address (frame_address),
        .o_frame_id      (frame_id),
        .o_frame_length  (frame_length),
        .o_status        (status),
        .o_for_host      (for_host),
        .o_last          (last)
    );

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic send_byte(input logic [7:0] b);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do begin
            @(posedge clk);
        end while (rx_ready !== 1'b1);
        sb.note_byte(b);
    endtask

    task automatic send_summed(input logic [7:0] b, inout logic [7:0] s, inout logic [7:0] a);
        send_byte(b);
        s = s + b;
        a = a + s;
    endtask

    task automatic send_frame(input logic [7:0] addr, input logic [7:0] id,
                              input logic [7:0] len, input bit mixed,
                              input bit bad_sum, input bit bad_add);
        logic [7:0] s;
        logic [7:0] a;
        logic [7:0] b;
        s = '0;
        a = '0;
        send_summed(cur_header, s, a);
        send_summed(addr, s, a);
        send_summed(id, s, a);
        send_summed(len, s, a);
        for (int k = 0; k < len; k++) begin
            if (mixed) begin
                b = (k % 3 == 0) ? cur_header : ((k % 3 == 1) ? 8'hFF : 8'h00);
            end else begin
                b = 8'($urandom);
            end
            send_summed(b, s, a);
        end
        send_byte(bad_sum ? (s ^ 8'($urandom_range(1, 255))) : s);
        send_byte(bad_add ? (a ^ 8'($urandom_range(1, 255))) : a);
    endtask

    task automatic rx_idle();
        rx_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_regs(input logic [7:0] hdr, input logic [7:0] host);
        cfg_we    <= 1'b1;
        cfg_index <= fpsac_pkg::CFG_HEADER_BYTE;
        cfg_data  <= hdr;
        @(posedge clk);
        sb.write_reg(fpsac_pkg::CFG_HEADER_BYTE, hdr);
        cur_header = hdr;
        cfg_index <= fpsac_pkg::CFG_HOST_ADDRESS;
        cfg_data  <= host;
        @(posedge clk);
        sb.write_reg(fpsac_pkg::CFG_HOST_ADDRESS, host);
        cur_host = host;
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] hdr, input logic [7:0] host,
                             input int target, input bit with_long, input bit with_hold);
        int         items;
        int         pick;
        int         n;
        logic [7:0] b;
        logic [7:0] len;
        logic [7:0] addr;
        write_regs(hdr, host);
        items = 0;
        if (with_hold) begin
            hold_req = 1'b1;
        end
        if (with_long) begin
            send_frame(8'($urandom), 8'($urandom), 8'd255, 1'b0, 1'b0, 1'b0);
            items += 261;
        end
        while (items < target) begin
            pick = $urandom_range(0, 15);
            if (pick < 3) begin
                n = $urandom_range(1, 3);
                repeat (n) begin
                    b = 8'($urandom);
                    if (b == cur_header) begin
                        b = b + 8'd1;
                    end
                    send_byte(b);
                end
                items += n;
            end else if (pick == 3) begin
                n = $urandom_range(1, 3);
                send_byte(cur_header);
                repeat (n) send_byte(8'($urandom));
                items += n + 1;
            end else begin
                len  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(7, 20))
                                                   : 8'($urandom_range(0, 6));
                addr = ($urandom_range(0, 3) == 0) ? cur_host : 8'($urandom);
                send_frame(addr, 8'($urandom), len, ($urandom_range(0, 9) == 0),
                           ($urandom_range(0, 7) == 0), ($urandom_range(0, 7) == 0));
                items += len + 6;
            end
        end
        rx_idle();
        drain();
    endtask

    initial begin : receiver
        int                 stall_left;
        int                 hold_left;
        fpsac_pkg::t_result got;
        stall_left = 0;
        hold_left  = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready) begin
                got.kind          = kind;
                got.data_byte     = data_byte;
                got.byte_index    = byte_index;
                got.frame_address = frame_address;
                got.frame_id      = frame_id;
                got.frame_length  = frame_length;
                got.status        = status;
                got.for_host      = for_host;
                got.last          = last;
                sb.check_result(got);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 3) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((rx_valid && rx_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        sb = new;
        sb.reset_state();
        sb.errors  = 0;
        cur_header = fpsac_pkg::HEADER_RESET;
        cur_host   = fpsac_pkg::ADDRESS_RESET;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        rst_n     <= 1'b0;
        rx_valid  <= 1'b0;
        rx_byte   <= 8'h00;
        cfg_we    <= 1'b0;
        cfg_index <= fpsac_pkg::CFG_HEADER_BYTE;
        cfg_data  <= 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        sb.reset_state();

        // Reset register values: noise, a good frame carrying the header value,
        // a zero-length frame failing the add check and one failing the sum check.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(8'h00, 8'hFF, 8'd3, 1'b1, 1'b0, 1'b0);
        send_frame(8'hFF, 8'h00, 8'd0, 1'b0, 1'b0, 1'b1);
        send_frame(8'h5A, 8'h11, 8'd1, 1'b0, 1'b1, 1'b0);
        rx_idle();
        drain();

        run_phase(8'h00, 8'hFF, 170, 1'b0, 1'b0);
        run_phase(8'hFF, 8'h00, 170, 1'b0, 1'b0);
        run_phase(8'($urandom), 8'($urandom), 170, 1'b0, 1'b1);
        run_phase(fpsac_pkg::HEADER_RESET, 8'($urandom), 170, 1'b1, 1'b0);
        run_phase(8'($urandom), 8'($urandom), 170, 1'b0, 1'b0);
        quiet = 1'b1;
        run_phase(8'($urandom), 8'($urandom), 170, 1'b0, 1'b0);

        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
